// ===== src/u2l_pkg.sv =====
package u2l_pkg;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD_C2    = 8'hC2;
  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] LEAD_E2    = 8'hE2;
  localparam logic [7:0] SEQ_E2_MID = 8'h80;
  localparam logic [7:0] SEQ_E2_END = 8'h99;
  localparam logic [7:0] C3_OFFSET  = 8'h40;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_APOS  = 8'h27;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       out_end;
  } out_t;

  // one queue entry holds every result of one input item
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== src/u2l_front.sv =====
module u2l_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  u2l_pkg::in_t    in_data,
  input  u2l_pkg::q_status_t q_status,
  output logic            push,
  output u2l_pkg::entry_t push_entry
);
  import u2l_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_C2     = 3'd1,
    M_C3     = 3'd2,
    M_E2     = 3'd3,
    M_E280   = 3'd4,
    M_SKIP   = 3'd5
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  mode_t      sc_mode;
  logic       sc_emit;
  logic [7:0] sc_char;
  logic [7:0] b;
  logic       cont;
  logic       accept;
  logic [1:0] n;
  out_t       r0;
  out_t       r1;

  assign b        = in_data.in_byte;
  assign cont     = (b & CONT_MASK) == CONT_TAG;
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // decode of a byte that starts a new character
  always_comb begin
    sc_emit = 1'b0;
    sc_char = CHAR_QMARK;
    sc_mode = M_NORMAL;
    if (!b[7]) begin
      sc_emit = 1'b1;
      sc_char = b;
    end else if (b == LEAD_C2) begin
      sc_mode = M_C2;
    end else if (b == LEAD_C3) begin
      sc_mode = M_C3;
    end else if (b == LEAD_E2) begin
      sc_mode = M_E2;
    end else begin
      sc_emit = 1'b1;
      sc_mode = M_SKIP;
    end
  end

  always_comb begin
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    mode_next = mode;
    case (mode)
      M_C2, M_C3: begin
        n  = 2'd1;
        r0 = '{out_char: cont ? ((mode == M_C2) ? b : b + C3_OFFSET) : CHAR_QMARK,
               has_char: 1'b1, out_end: 1'b0};
        mode_next = M_NORMAL;
      end
      M_E2, M_E280: begin
        if ((mode == M_E2) && (b == SEQ_E2_MID)) begin
          mode_next = M_E280;
        end else if ((mode == M_E280) && (b == SEQ_E2_END)) begin
          n         = 2'd1;
          r0        = '{out_char: CHAR_APOS, has_char: 1'b1, out_end: 1'b0};
          mode_next = M_NORMAL;
        end else begin
          // broken sequence: '?' now; a continuation byte is skipped, else it starts anew
          n  = 2'd1;
          r0 = '{out_char: CHAR_QMARK, has_char: 1'b1, out_end: 1'b0};
          if (cont) begin
            mode_next = M_SKIP;
          end else begin
            mode_next = sc_mode;
            if (sc_emit) begin
              n  = 2'd2;
              r1 = '{out_char: sc_char, has_char: 1'b1, out_end: 1'b0};
            end
          end
        end
      end
      M_SKIP: begin
        if (cont) begin
          mode_next = M_SKIP;
        end else begin
          mode_next = sc_mode;
          if (sc_emit) begin
            n  = 2'd1;
            r0 = '{out_char: sc_char, has_char: 1'b1, out_end: 1'b0};
          end
        end
      end
      default: begin
        mode_next = sc_mode;
        if (sc_emit) begin
          n  = 2'd1;
          r0 = '{out_char: sc_char, has_char: 1'b1, out_end: 1'b0};
        end
      end
    endcase

    if (in_data.in_end) begin
      // lead cut off by the end of the string
      if (mode_next == M_C2 || mode_next == M_C3 || mode_next == M_E2 ||
          mode_next == M_E280) begin
        if (n == 2'd0) begin
          r0 = '{out_char: CHAR_QMARK, has_char: 1'b1, out_end: 1'b0};
        end else begin
          r1 = '{out_char: CHAR_QMARK, has_char: 1'b1, out_end: 1'b0};
        end
        n = n + 2'd1;
      end
      mode_next = M_NORMAL;
      if (n == 2'd0) begin
        n  = 2'd1;
        r0 = '{out_char: 8'h00, has_char: 1'b0, out_end: 1'b0};
      end
      if (n == 2'd1) begin
        r0.out_end = 1'b1;
      end else begin
        r1.out_end = 1'b1;
      end
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_entry.two = (n == 2'd2);
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

// ===== src/u2l_queue.sv =====
module u2l_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u2l_pkg::entry_t    push_entry,
  input  logic               pop,
  output u2l_pkg::entry_t    head,
  output u2l_pkg::q_status_t q_status
);
  import u2l_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/u2l_back.sv =====
module u2l_back (
  input  logic               clk,
  input  logic               rst,
  input  u2l_pkg::entry_t    head,
  input  u2l_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u2l_pkg::out_t      out_data
);
  import u2l_pkg::*;

  logic sel;
  logic load;
  logic take;

  // output register refills whenever it is empty or being taken
  assign load = !out_valid || out_ready;
  assign take = load && !q_status.empty;
  assign pop  = take && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (take) begin
        sel <= !sel && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= sel ? head.r1 : head.r0;
    end
  end

endmodule

// ===== src/utf8_to_latin1_stream_core.sv =====
// utf-8 to latin-1 stream decoder
// input channel (in_valid/in_ready/in_data) takes one utf-8 byte per item,
// with in_end set on the last byte of a string. output channel
// (out_valid/out_ready/out_data) gives one latin-1 character per item; an
// item with has_char low is only an end marker, and out_end marks the final
// result of a string.
// one byte is accepted every cycle while the four-entry queue between the
// decoder front and the output back has room. a byte gives zero, one or two
// results; the back sends one result per cycle while the receiver takes them,
// so a byte with two results sends them one after the other. each result is
// written into the queue and then loaded into the output register.
// reset clears the decode mode, empties the queue and drops out_valid; the
// block is ready in the first cycle after reset.
// when the receiver stalls, the output register holds its result, the queue
// fills, and in_ready falls once the queue is full.
module utf8_to_latin1_stream_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  u2l_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output u2l_pkg::out_t out_data
);
  import u2l_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  u2l_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  u2l_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  u2l_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
